// File: hw/rtl/first_fit_offset_allocator_macros.svh
// Assertion macros used by the allocator RTL
`ifndef FIRST_FIT_OFFSET_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_OFFSET_ALLOCATOR_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low
`define FOFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define FOFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fofa_pkg.sv
// Types, codes and helpers of the first-fit offset allocator
package fofa_pkg;

  localparam int unsigned AddrBits = 40;
  localparam int unsigned IdSlots  = 256;
  localparam int unsigned IdBits   = 8;
  // working width: holds any size (up to 2^32) and any rounded offset
  localparam int unsigned WorkBits = ((AddrBits > 33) ? AddrBits : 33) + 1;
  localparam int unsigned EntBits  = 2 * AddrBits;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [WorkBits-1:0] work_t;
  typedef logic [EntBits-1:0]  entry_t;

  localparam work_t ArenaLimit = work_t'((64'd1 << AddrBits) - 64'd1);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_BAD_ID    = 3'd2,
    ST_FREE_FULL = 3'd3,
    ST_ID_FULL   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] request_bytes;
    logic [4:0]  align_log2;
    logic [7:0]  free_id;
  } in_t;

  typedef struct packed {
    logic [39:0] offset;
    logic [7:0]  given_id;
    logic [39:0] arena_bytes;
    logic [2:0]  status;
  } out_t;

  // round x up to the alignment whose low-bit mask is m
  function automatic work_t round_up(work_t x, work_t m);
    return (x + m) & ~m;
  endfunction

endpackage

// File: hw/rtl/fofa_ram.sv
// Generic one-write, one-read RAM with registered read data
module fofa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: hw/rtl/fofa_sizer.sv
// Alignment mask and rounded size of an allocation request
module fofa_sizer (
  input  logic [31:0]     bytes_i,
  input  logic [4:0]      align_log2_i,
  output fofa_pkg::work_t mask_o,
  output fofa_pkg::work_t size_o
);
  import fofa_pkg::*;

  work_t base_mask;
  work_t req_mask;

  // large requests align to 64 KiB, the rest to 128 bytes
  assign base_mask = (bytes_i > 32'd32768) ? work_t'(17'h0FFFF) : work_t'(8'h7F);
  assign req_mask  = (work_t'(1) << align_log2_i) - work_t'(1);
  assign mask_o    = base_mask | req_mask;
  assign size_o    = round_up(work_t'(bytes_i), mask_o);

endmodule

// File: hw/rtl/first_fit_offset_allocator.sv
// First-fit offset allocator: sequencer around the free-list and id-range RAMs
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (fofa_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (fofa_pkg::out_t)
//
// One item at a time. Its steps include the checks, the id-range read (free only),
// the first-fit scan, which reads one entry a cycle up to the hit, a shift that
// moves the entries behind the hit one a cycle when a range is inserted or
// removed, and the final writes. Errors found at the check stage go straight
// to the finish step.
// Reset clears the list length, arena size, id counter and in-use bits; the
// RAMs need no clearing. A stalled result is held in the output register; the
// next item may be taken meanwhile and waits at its last step.
`include "first_fit_offset_allocator_macros.svh"

module first_fit_offset_allocator #(
  parameter int unsigned FreeSlots = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fofa_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fofa_pkg::out_t  out_data_o
);
  import fofa_pkg::*;

  localparam int unsigned IdxW = $clog2(FreeSlots);
  localparam int unsigned CntW = $clog2(FreeSlots + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FreeSlots);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CHECK  = 10'b00_0000_0010,
    S_UREAD  = 10'b00_0000_0100,
    S_SCAN   = 10'b00_0000_1000,
    S_TAIL   = 10'b00_0001_0000,
    S_NXRD   = 10'b00_0010_0000,
    S_HIT    = 10'b00_0100_0000,
    S_SHIFT  = 10'b00_1000_0000,
    S_WRITE  = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // payload registers
  in_t             req_q, req_d;
  work_t           mask_q, mask_d, size_q, size_d;
  addr_t           cb_q, cb_d, ce_q, ce_d;
  addr_t           hb_q, hb_d, he_q, he_d;
  logic [IdxW-1:0] hidx_q, hidx_d, pidx_q, pidx_d, sra_q, sra_d;
  logic [IdxW-1:0] w0a_q, w0a_d, w1a_q, w1a_d;
  entry_t          w0d_q, w0d_d, w1d_q, w1d_d;
  addr_t           anew_q, anew_d, off_q, off_d;
  out_t            out_q, out_d;

  // control registers
  logic [CntW-1:0]    ra_q, ra_d, sh_n_q, sh_n_d, fcnt_q, fcnt_d;
  logic               pend_q, pend_d, found_q, found_d, sh_up_q, sh_up_d;
  logic               w0v_q, w0v_d, w1v_q, w1v_d;
  logic               cinc_q, cinc_d, cdec_q, cdec_d, aupd_q, aupd_d;
  status_e            status_q, status_d;
  addr_t              arena_q, arena_d;
  logic [IdBits-1:0]  next_id_q, next_id_d;
  logic [IdSlots-1:0] used_valid_q, used_valid_d;
  logic               out_valid_q, out_valid_d;

  // RAM ports
  logic            fl_re, fl_we;
  logic [IdxW-1:0] fl_raddr, fl_waddr;
  entry_t          fl_wdata, fl_rdata;
  logic            ur_re, uw_we;
  entry_t          ur_rdata, uw_wdata;
  addr_t           fl_b, fl_e;

  work_t sz_mask, sz_size;
  work_t sc_b, ht_b, ht_bsz, tl_base, tl_off, tl_tot;
  logic  sc_hit, ht_gap, ht_rem, ht_nv, is_alloc;
  logic [CntW-1:0] hidx_c;

  fofa_sizer u_sizer (
    .bytes_i      (req_q.request_bytes),
    .align_log2_i (req_q.align_log2),
    .mask_o       (sz_mask),
    .size_o       (sz_size)
  );

  fofa_ram #(.Width(EntBits), .Depth(FreeSlots)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .re_i    (fl_re),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  fofa_ram #(.Width(EntBits), .Depth(IdSlots)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (uw_we),
    .waddr_i (next_id_q),
    .wdata_i (uw_wdata),
    .re_i    (ur_re),
    .raddr_i (req_q.free_id),
    .rdata_o (ur_rdata)
  );

  assign fl_b     = fl_rdata[EntBits-1:AddrBits];
  assign fl_e     = fl_rdata[AddrBits-1:0];
  assign is_alloc = (req_q.cmd == CMD_ALLOC);
  assign uw_wdata = {off_q, AddrBits'(work_t'(off_q) + size_q)};

  // scan: fit test of the entry just read
  assign sc_b   = round_up(work_t'(fl_b), mask_q);
  assign sc_hit = is_alloc ?
                  ((sc_b <= work_t'(fl_e)) && ((work_t'(fl_e) - sc_b) >= size_q)) :
                  (fl_e >= cb_q);

  // hit entry
  assign hidx_c = CntW'(hidx_q);
  assign ht_b   = round_up(work_t'(hb_q), mask_q);
  assign ht_bsz = ht_b + size_q;
  assign ht_gap = (ht_b != work_t'(hb_q));
  assign ht_rem = (work_t'(he_q) != ht_bsz);
  assign ht_nv  = found_q && ((hidx_c + CntOne) < fcnt_q);

  // arena tail
  assign tl_base = (fcnt_q != '0 && he_q == arena_q) ? work_t'(hb_q) : work_t'(arena_q);
  assign tl_off  = round_up(tl_base, mask_q);
  assign tl_tot  = tl_off + size_q;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    mask_d       = mask_q;
    size_d       = size_q;
    cb_d         = cb_q;
    ce_d         = ce_q;
    hb_d         = hb_q;
    he_d         = he_q;
    hidx_d       = hidx_q;
    pidx_d       = pidx_q;
    sra_d        = sra_q;
    w0a_d        = w0a_q;
    w0d_d        = w0d_q;
    w1a_d        = w1a_q;
    w1d_d        = w1d_q;
    anew_d       = anew_q;
    off_d        = off_q;
    out_d        = out_q;
    ra_d         = ra_q;
    sh_n_d       = sh_n_q;
    fcnt_d       = fcnt_q;
    pend_d       = pend_q;
    found_d      = found_q;
    sh_up_d      = sh_up_q;
    w0v_d        = w0v_q;
    w1v_d        = w1v_q;
    cinc_d       = cinc_q;
    cdec_d       = cdec_q;
    aupd_d       = aupd_q;
    status_d     = status_q;
    arena_d      = arena_q;
    next_id_d    = next_id_q;
    used_valid_d = used_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    fl_re        = 1'b0;
    fl_raddr     = '0;
    fl_we        = 1'b0;
    fl_waddr     = '0;
    fl_wdata     = '0;
    ur_re        = 1'b0;
    uw_we        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        mask_d   = sz_mask;
        size_d   = sz_size;
        cinc_d   = 1'b0;
        cdec_d   = 1'b0;
        aupd_d   = 1'b0;
        w0v_d    = 1'b0;
        w1v_d    = 1'b0;
        ra_d     = '0;
        pend_d   = 1'b0;
        found_d  = 1'b0;
        status_d = ST_OK;
        if (is_alloc) begin
          if (req_q.request_bytes == '0) begin
            status_d = ST_ZERO_SIZE;
            state_d  = S_FINISH;
          end else if (used_valid_q[next_id_q]) begin
            status_d = ST_ID_FULL;
            state_d  = S_FINISH;
          end else begin
            state_d = S_SCAN;
          end
        end else if (!used_valid_q[req_q.free_id]) begin
          status_d = ST_BAD_ID;
          state_d  = S_FINISH;
        end else begin
          ur_re   = 1'b1;
          state_d = S_UREAD;
        end
      end

      S_UREAD: begin
        cb_d    = ur_rdata[EntBits-1:AddrBits];
        ce_d    = ur_rdata[AddrBits-1:0];
        state_d = S_SCAN;
      end

      S_SCAN: begin
        // read one entry a cycle, test the one read last cycle
        if (ra_q < fcnt_q) begin
          fl_re    = 1'b1;
          fl_raddr = ra_q[IdxW-1:0];
          ra_d     = ra_q + CntOne;
          pidx_d   = ra_q[IdxW-1:0];
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          hb_d   = fl_b;
          he_d   = fl_e;
          hidx_d = pidx_q;
        end
        if (pend_q && sc_hit) begin
          found_d = 1'b1;
          pend_d  = 1'b0;
          if (!is_alloc && ((CntW'(pidx_q) + CntOne) < fcnt_q)) begin
            state_d = S_NXRD;
          end else begin
            state_d = S_HIT;
          end
        end else if (ra_q >= fcnt_q) begin
          pend_d  = 1'b0;
          state_d = is_alloc ? S_TAIL : S_HIT;
        end
      end

      S_NXRD: begin
        fl_re    = 1'b1;
        fl_raddr = hidx_q + IdxW'(1);
        state_d  = S_HIT;
      end

      S_HIT: begin
        pend_d  = 1'b0;
        sh_n_d  = '0;
        state_d = S_SHIFT;
        if (is_alloc) begin
          off_d = AddrBits'(ht_b);
          if (ht_gap && ht_rem) begin
            if (fcnt_q >= CntFull) begin
              status_d = ST_FREE_FULL;
              state_d  = S_FINISH;
            end else begin
              // open a slot after the hit: gap stays at i, remainder goes to i+1
              sh_up_d = 1'b1;
              sh_n_d  = fcnt_q - hidx_c - CntOne;
              sra_d   = IdxW'(fcnt_q - CntOne);
              w0v_d   = 1'b1;
              w0a_d   = hidx_q;
              w0d_d   = {hb_q, AddrBits'(ht_b)};
              w1v_d   = 1'b1;
              w1a_d   = hidx_q + IdxW'(1);
              w1d_d   = {AddrBits'(ht_bsz), he_q};
              cinc_d  = 1'b1;
            end
          end else if (ht_gap) begin
            w0v_d = 1'b1;
            w0a_d = hidx_q;
            w0d_d = {hb_q, AddrBits'(ht_b)};
          end else if (ht_rem) begin
            w0v_d = 1'b1;
            w0a_d = hidx_q;
            w0d_d = {AddrBits'(ht_bsz), he_q};
          end else begin
            sh_up_d = 1'b0;
            sh_n_d  = fcnt_q - hidx_c - CntOne;
            sra_d   = hidx_q + IdxW'(1);
            cdec_d  = 1'b1;
          end
        end else if (!found_q) begin
          if (fcnt_q >= CntFull) begin
            status_d = ST_FREE_FULL;
            state_d  = S_FINISH;
          end else begin
            w0v_d  = 1'b1;
            w0a_d  = IdxW'(fcnt_q);
            w0d_d  = {cb_q, ce_q};
            cinc_d = 1'b1;
          end
        end else if (he_q == cb_q && ht_nv && fl_b == ce_q) begin
          // bridge: merge three ranges, drop the one after the hit
          sh_up_d = 1'b0;
          sh_n_d  = fcnt_q - hidx_c - CntW'(2);
          sra_d   = hidx_q + IdxW'(2);
          w0v_d   = 1'b1;
          w0a_d   = hidx_q;
          w0d_d   = {hb_q, fl_e};
          cdec_d  = 1'b1;
        end else if (hb_q == ce_q) begin
          w0v_d = 1'b1;
          w0a_d = hidx_q;
          w0d_d = {cb_q, he_q};
        end else if (he_q == cb_q) begin
          w0v_d = 1'b1;
          w0a_d = hidx_q;
          w0d_d = {hb_q, ce_q};
        end else if (fcnt_q >= CntFull) begin
          status_d = ST_FREE_FULL;
          state_d  = S_FINISH;
        end else begin
          sh_up_d = 1'b1;
          sh_n_d  = fcnt_q - hidx_c;
          sra_d   = IdxW'(fcnt_q - CntOne);
          w0v_d   = 1'b1;
          w0a_d   = hidx_q;
          w0d_d   = {cb_q, ce_q};
          cinc_d  = 1'b1;
        end
      end

      S_TAIL: begin
        pend_d  = 1'b0;
        sh_n_d  = '0;
        off_d   = AddrBits'(tl_off);
        anew_d  = AddrBits'(tl_tot);
        aupd_d  = 1'b1;
        state_d = S_SHIFT;
        if (tl_tot > ArenaLimit) begin
          status_d = ST_OVERFLOW;
          state_d  = S_FINISH;
        end else if (fcnt_q != '0 && he_q == arena_q) begin
          // last free range touches the tail: grow from it
          if (tl_off != work_t'(hb_q)) begin
            w0v_d = 1'b1;
            w0a_d = IdxW'(fcnt_q - CntOne);
            w0d_d = {hb_q, AddrBits'(tl_off)};
          end else begin
            cdec_d = 1'b1;
          end
        end else if (tl_off != work_t'(arena_q)) begin
          if (fcnt_q >= CntFull) begin
            status_d = ST_FREE_FULL;
            state_d  = S_FINISH;
          end else begin
            w0v_d  = 1'b1;
            w0a_d  = IdxW'(fcnt_q);
            w0d_d  = {arena_q, AddrBits'(tl_off)};
            cinc_d = 1'b1;
          end
        end
      end

      S_SHIFT: begin
        // move one entry a cycle; each write takes the entry held in the RAM read register
        if (pend_q) begin
          fl_we    = 1'b1;
          fl_waddr = sh_up_q ? (pidx_q + IdxW'(1)) : (pidx_q - IdxW'(1));
          fl_wdata = fl_rdata;
        end
        if (sh_n_q != '0) begin
          fl_re    = 1'b1;
          fl_raddr = sra_q;
          pidx_d   = sra_q;
          pend_d   = 1'b1;
          sh_n_d   = sh_n_q - CntOne;
          sra_d    = sh_up_q ? (sra_q - IdxW'(1)) : (sra_q + IdxW'(1));
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        if (w0v_q) begin
          fl_we    = 1'b1;
          fl_waddr = w0a_q;
          fl_wdata = w0d_q;
          w0v_d    = 1'b0;
        end else if (w1v_q) begin
          fl_we    = 1'b1;
          fl_waddr = w1a_q;
          fl_wdata = w1d_q;
          w1v_d    = 1'b0;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        // hold until the output register is free, then commit
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.offset      = '0;
          out_d.given_id    = '0;
          out_d.arena_bytes = arena_q;
          state_d           = S_IDLE;
          if (status_q == ST_OK) begin
            fcnt_d = fcnt_q + CntW'(cinc_q) - CntW'(cdec_q);
            if (aupd_q) begin
              arena_d           = anew_q;
              out_d.arena_bytes = anew_q;
            end
            if (is_alloc) begin
              uw_we                   = 1'b1;
              used_valid_d[next_id_q] = 1'b1;
              next_id_d               = next_id_q + IdBits'(1);
              out_d.offset            = off_q;
              out_d.given_id          = next_id_q;
            end else begin
              used_valid_d[req_q.free_id] = 1'b0;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ra_q         <= '0;
      sh_n_q       <= '0;
      fcnt_q       <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      sh_up_q      <= 1'b0;
      w0v_q        <= 1'b0;
      w1v_q        <= 1'b0;
      cinc_q       <= 1'b0;
      cdec_q       <= 1'b0;
      aupd_q       <= 1'b0;
      status_q     <= ST_OK;
      arena_q      <= '0;
      next_id_q    <= '0;
      used_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ra_q         <= ra_d;
      sh_n_q       <= sh_n_d;
      fcnt_q       <= fcnt_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      sh_up_q      <= sh_up_d;
      w0v_q        <= w0v_d;
      w1v_q        <= w1v_d;
      cinc_q       <= cinc_d;
      cdec_q       <= cdec_d;
      aupd_q       <= aupd_d;
      status_q     <= status_d;
      arena_q      <= arena_d;
      next_id_q    <= next_id_d;
      used_valid_q <= used_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    mask_q <= mask_d;
    size_q <= size_d;
    cb_q   <= cb_d;
    ce_q   <= ce_d;
    hb_q   <= hb_d;
    he_q   <= he_d;
    hidx_q <= hidx_d;
    pidx_q <= pidx_d;
    sra_q  <= sra_d;
    w0a_q  <= w0a_d;
    w0d_q  <= w0d_d;
    w1a_q  <= w1a_d;
    w1d_q  <= w1d_d;
    anew_q <= anew_d;
    off_q  <= off_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FOFA_ASSERT(a_cnt_range, fcnt_q <= CntFull, "free list longer than its RAM")
  `FOFA_ASSERT(a_no_collide, !(fl_we && fl_re) || (fl_waddr != fl_raddr),
               "free RAM read and write collide")
  `FOFA_ASSERT(a_arena_mono, arena_q >= $past(arena_q), "arena shrank")
  `FOFA_ASSERT_NEXT(a_id_commit,
                    state_q == S_FINISH && (!out_valid_q || out_ready_i) &&
                    status_q == ST_OK && req_q.cmd == CMD_ALLOC,
                    used_valid_q[$past(next_id_q)], "allocated id not marked in use")

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the first-fit offset allocator: directed table, then checked random traffic
`timescale 1ns / 100ps

module tb_top;
  import fofa_pkg::*;

  localparam int unsigned FreeDepth = 64;
  localparam int unsigned StallLimit = 5000;
  localparam logic [63:0] ArenaTop = (64'd1 << AddrBits) - 64'd1;

  typedef struct {
    in_t  item;
    bit   known;
    out_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // mirror of the allocator state
  logic [63:0] hole_b [FreeDepth];
  logic [63:0] hole_e [FreeDepth];
  int unsigned hole_n = 0;
  logic [63:0] buf_b [IdSlots];
  logic [63:0] buf_e [IdSlots];
  bit          buf_live [IdSlots];
  int unsigned id_next = 0;
  logic [63:0] arena_sz = '0;

  out_t        pending_results [$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;

  first_fit_offset_allocator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  function automatic bit align_up(input logic [63:0] x, input logic [63:0] al,
                                  output logic [63:0] r);
    logic [63:0] m;
    m = al - 64'd1;
    if (x > ~m) return 1'b0;
    r = (x + m) & ~m;
    return 1'b1;
  endfunction

  function automatic void hole_insert(input int unsigned pos, input logic [63:0] b,
                                      input logic [63:0] e);
    for (int unsigned k = hole_n; k > pos; k--) begin
      hole_b[k] = hole_b[k-1];
      hole_e[k] = hole_e[k-1];
    end
    hole_b[pos] = b;
    hole_e[pos] = e;
    hole_n++;
  endfunction

  function automatic void hole_remove(input int unsigned pos);
    for (int unsigned k = pos; k + 1 < hole_n; k++) begin
      hole_b[k] = hole_b[k+1];
      hole_e[k] = hole_e[k+1];
    end
    hole_n--;
  endfunction

  function automatic status_e place_buffer(input logic [63:0] bytes, input int unsigned alog,
                                           output logic [63:0] off);
    logic [63:0] al, req, sz, b, tot;
    bit gap, rem;
    int unsigned last;
    off = '0;
    req = 64'd1 << alog;
    al = (bytes > 64'd32768) ? 64'd65536 : 64'd128;
    if (bytes == 0) return ST_ZERO_SIZE;
    if (buf_live[id_next]) return ST_ID_FULL;
    if (al < req) al = req;
    sz = (bytes + al - 64'd1) & ~(al - 64'd1);
    for (int unsigned i = 0; i < hole_n; i++) begin
      if (!align_up(hole_b[i], al, b)) continue;
      if (b > hole_e[i] || hole_e[i] - b < sz) continue;
      gap = b != hole_b[i];
      rem = hole_e[i] - b > sz;
      if (gap && rem && hole_n >= FreeDepth) return ST_FREE_FULL;
      if (gap) begin
        if (rem) begin
          hole_insert(i, hole_b[i], b);
          hole_b[i+1] = b + sz;
        end else hole_e[i] = b;
      end else if (rem) hole_b[i] = b + sz;
      else hole_remove(i);
      off = b;
      buf_b[id_next] = off;
      buf_e[id_next] = off + sz;
      buf_live[id_next] = 1'b1;
      id_next = (id_next + 1) % IdSlots;
      return ST_OK;
    end
    // nothing fits: grow the tail, reusing a hole that ends there
    if (hole_n > 0 && hole_e[hole_n-1] == arena_sz) begin
      last = hole_n - 1;
      if (!align_up(hole_b[last], al, b)) return ST_OVERFLOW;
      if (b > ArenaTop || sz > ArenaTop - b) return ST_OVERFLOW;
      tot = b + sz;
      if (b != hole_b[last]) hole_e[last] = b;
      else hole_n--;
    end else begin
      if (!align_up(arena_sz, al, b)) return ST_OVERFLOW;
      if (b > ArenaTop || sz > ArenaTop - b) return ST_OVERFLOW;
      tot = b + sz;
      if (b != arena_sz) begin
        if (hole_n >= FreeDepth) return ST_FREE_FULL;
        hole_insert(hole_n, arena_sz, b);
      end
    end
    arena_sz = tot;
    off = b;
    buf_b[id_next] = off;
    buf_e[id_next] = off + sz;
    buf_live[id_next] = 1'b1;
    id_next = (id_next + 1) % IdSlots;
    return ST_OK;
  endfunction

  function automatic status_e release_buffer(input int unsigned id);
    logic [63:0] cb, ce;
    int unsigned i;
    if (!buf_live[id]) return ST_BAD_ID;
    cb = buf_b[id];
    ce = buf_e[id];
    for (i = 0; i < hole_n; i++)
      if (hole_e[i] >= cb) break;
    if (i == hole_n) begin
      if (hole_n >= FreeDepth) return ST_FREE_FULL;
      hole_insert(hole_n, cb, ce);
    end else if (hole_e[i] == cb && i + 1 < hole_n && hole_b[i+1] == ce) begin
      hole_e[i] = hole_e[i+1];
      hole_remove(i + 1);
    end else if (hole_b[i] == ce) hole_b[i] = cb;
    else if (hole_e[i] == cb) hole_e[i] = ce;
    else begin
      if (hole_n >= FreeDepth) return ST_FREE_FULL;
      hole_insert(i, cb, ce);
    end
    buf_live[id] = 1'b0;
    return ST_OK;
  endfunction

  function automatic out_t allocator_result(input in_t it);
    out_t r;
    logic [63:0] off;
    status_e st;
    int unsigned gid;
    gid = id_next;
    r = '0;
    if (it.cmd == CMD_ALLOC) begin
      st = place_buffer(64'(it.request_bytes), 32'(it.align_log2), off);
      if (st == ST_OK) begin
        r.offset = off[39:0];
        r.given_id = gid[7:0];
      end
    end else st = release_buffer(32'(it.free_id));
    r.arena_bytes = arena_sz[39:0];
    r.status = st;
    return r;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int unsigned live, pick, roll, alloc_pct;
    live = 0;
    foreach (buf_live[k]) live += 32'(buf_live[k]);
    alloc_pct = (live < 32) ? 70 : (live > 220) ? 30 : 50;
    roll = $urandom_range(0, 99);
    it = '0;
    it.request_bytes = $urandom();
    it.align_log2 = 5'($urandom());
    it.free_id = 8'($urandom());
    if (roll < 5) begin
      // noise: zero size or a random id
      it.cmd = ($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_FREE;
      if (it.cmd == CMD_ALLOC) it.request_bytes = '0;
    end else if (roll < 5 + alloc_pct || live == 0) begin
      it.cmd = CMD_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 80) it.request_bytes = $urandom_range(1, 4096);
      else if (pick < 97) it.request_bytes = $urandom_range(32769, 300000);
      if ($urandom_range(0, 19) != 0) it.align_log2 = 5'($urandom_range(0, 12));
    end else begin
      it.cmd = CMD_FREE;
      pick = $urandom_range(0, IdSlots - 1);
      while (!buf_live[pick]) pick = (pick + 1) % IdSlots;
      it.free_id = pick[7:0];
    end
    return it;
  endfunction

  task automatic send(input in_t it, input bit known, input out_t res);
    out_t got;
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    got = allocator_result(it);
    pending_results.push_back(known ? res : got);
  endtask

  always @(posedge clk_i) begin
    if (!steady) out_ready_i <= ($urandom_range(0, 99) >= 33);
    else out_ready_i <= 1'b1;
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, out_data_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data_o.offset !== exp_r.offset) begin
          $display("%0t: offset expected %0h actual %0h", $time, exp_r.offset,
                   out_data_o.offset);
          errors++;
        end
        if (out_data_o.given_id !== exp_r.given_id) begin
          $display("%0t: given_id expected %0d actual %0d", $time, exp_r.given_id,
                   out_data_o.given_id);
          errors++;
        end
        if (out_data_o.arena_bytes !== exp_r.arena_bytes) begin
          $display("%0t: arena_bytes expected %0h actual %0h", $time, exp_r.arena_bytes,
                   out_data_o.arena_bytes);
          errors++;
        end
        if (out_data_o.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_data_o.status);
          errors++;
        end
      end
    end
  end

  // stop if no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    out_t none;
    none = '0;
    rows.push_back('{in_t'{CMD_ALLOC, 32'd1, 5'd0, 8'd0}, 1'b1,
                     out_t'{40'd0, 8'd0, 40'd128, ST_OK}});
    rows.push_back('{in_t'{CMD_ALLOC, 32'd0, 5'd3, 8'd0}, 1'b1,
                     out_t'{40'd0, 8'd0, 40'd128, ST_ZERO_SIZE}});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd200}, 1'b1,
                     out_t'{40'd0, 8'd0, 40'd128, ST_BAD_ID}});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd0}, 1'b1,
                     out_t'{40'd0, 8'd0, 40'd128, ST_OK}});
    rows.push_back('{in_t'{CMD_ALLOC, 32'd32769, 5'd0, 8'd0}, 1'b1,
                     out_t'{40'd0, 8'd1, 40'd65536, ST_OK}});
    rows.push_back('{in_t'{CMD_ALLOC, 32'hFFFF_FFFF, 5'd31, 8'd0}, 1'b0, none});
    rows.push_back('{in_t'{CMD_ALLOC, 32'd100, 5'd16, 8'd0}, 1'b0, none});
    rows.push_back('{in_t'{CMD_ALLOC, 32'd5000, 5'd7, 8'd0}, 1'b0, none});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd2}, 1'b0, none});
    rows.push_back('{in_t'{CMD_FREE, 32'hFFFF_FFFF, 5'd31, 8'd255}, 1'b0, none});
    rows.push_back('{in_t'{CMD_ALLOC, 32'd32768, 5'd0, 8'd0}, 1'b0, none});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd1}, 1'b0, none});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd3}, 1'b0, none});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd4}, 1'b0, none});
    rows.push_back('{in_t'{CMD_ALLOC, 32'd64, 5'd5, 8'd0}, 1'b0, none});
    rows.push_back('{in_t'{CMD_ALLOC, 32'h8000_0000, 5'd31, 8'd0}, 1'b0, none});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd5}, 1'b0, none});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd6}, 1'b0, none});
    rows.push_back('{in_t'{CMD_ALLOC, 32'd1, 5'd31, 8'd0}, 1'b0, none});
    rows.push_back('{in_t'{CMD_FREE, 32'd0, 5'd0, 8'd6}, 1'b0, none});
    foreach (buf_live[k]) buf_live[k] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[r]) send(rows[r].item, rows[r].known, rows[r].res);
    for (int n = 0; n < 1530; n++) begin
      steady = (n >= 600 && n < 900);
      send(random_item(), 1'b0, none);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/fofa_pkg.sv
hw/rtl/fofa_ram.sv
hw/rtl/fofa_sizer.sv
hw/rtl/first_fit_offset_allocator.sv
tb/sv/tb_top.sv
